### sv/mhbi_pkg.sv
// ----------------------------------------------------------------------------
// mhbi_pkg
// Types and constants shared by the multi-hash bucket index unit.
// ----------------------------------------------------------------------------
package mhbi_pkg;

  localparam int KIND_FIELDS = 4;
  localparam int BUCKET_W    = 18;
  localparam int ADDR_W      = 64;
  localparam int MOD_W       = 17;
  localparam int PADDR_W     = 5;

  localparam logic [2:0] KIND_SIMPLE = 3'd0;
  localparam logic [2:0] KIND_XOR    = 3'd1;
  localparam logic [2:0] KIND_SHIFT  = 3'd2;
  localparam logic [2:0] KIND_MATRIX = 3'd3;
  localparam logic [2:0] KIND_PRIME  = 3'd4;

  localparam logic [2:0] REG_HASH_SHIFT    = 3'd0;
  localparam logic [2:0] REG_BUCKET_BITS   = 3'd1;
  localparam logic [2:0] REG_PARTITIONED   = 3'd2;
  localparam logic [2:0] REG_SLOT_COUNT    = 3'd3;
  localparam logic [2:0] REG_SLOT_KINDS    = 3'd4;
  localparam logic [2:0] REG_SLOT_ARGS     = 3'd5;
  localparam logic [2:0] REG_PRIME_MODULUS = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SLOT,
    ST_MAT,
    ST_DRAIN,
    ST_DIV,
    ST_INSERT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [5:0]  hash_shift;
    logic [4:0]  bucket_bits;
    logic        partitioned;
    logic [2:0]  slot_count;
    logic [11:0] slot_kinds;
    logic [23:0] slot_args;
    logic [16:0] prime_modulus;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic wr_row;
    logic next_slot;
    logic mat_start;
    logic mat_step;
    logic div_start;
    logic div_step;
    logic insert;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       slot_done;
    logic       row_last;
    logic       div_last;
    logic       emit_last;
    logic       list_empty;
  } status_t;

endpackage

### sv/mhbi_regs.sv
// ----------------------------------------------------------------------------
// mhbi_regs
// APB-style configuration register file.
// ----------------------------------------------------------------------------
module mhbi_regs
  import mhbi_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  cfg_t       cfg_r;
  logic [2:0] idx;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= {($bits(cfg_t)-MOD_W)'(0), MOD_W'(1)};
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_HASH_SHIFT:    cfg_r.hash_shift    <= pwdata[5:0];
        REG_BUCKET_BITS:   cfg_r.bucket_bits   <= pwdata[4:0];
        REG_PARTITIONED:   cfg_r.partitioned   <= pwdata[0];
        REG_SLOT_COUNT:    cfg_r.slot_count    <= pwdata[2:0];
        REG_SLOT_KINDS:    cfg_r.slot_kinds    <= pwdata[11:0];
        REG_SLOT_ARGS:     cfg_r.slot_args     <= pwdata[23:0];
        REG_PRIME_MODULUS: cfg_r.prime_modulus <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_HASH_SHIFT:    prdata = {26'd0, cfg_r.hash_shift};
      REG_BUCKET_BITS:   prdata = {27'd0, cfg_r.bucket_bits};
      REG_PARTITIONED:   prdata = {31'd0, cfg_r.partitioned};
      REG_SLOT_COUNT:    prdata = {29'd0, cfg_r.slot_count};
      REG_SLOT_KINDS:    prdata = {20'd0, cfg_r.slot_kinds};
      REG_SLOT_ARGS:     prdata = {8'd0, cfg_r.slot_args};
      REG_PRIME_MODULUS: prdata = {15'd0, cfg_r.prime_modulus};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

### sv/mhbi_ctrl.sv
// ----------------------------------------------------------------------------
// mhbi_ctrl
// Sequencer that walks the hash slots and drives the datapath.
// ----------------------------------------------------------------------------
module mhbi_ctrl
  import mhbi_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  logic    opcode,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start && !opcode) state_nxt = ST_SLOT;
      end
      ST_SLOT: begin
        if (status.slot_done) begin
          state_nxt = status.list_empty ? ST_IDLE : ST_EMIT;
        end else begin
          unique case (status.kind)
            KIND_SIMPLE, KIND_XOR, KIND_SHIFT: state_nxt = ST_INSERT;
            KIND_MATRIX:                       state_nxt = ST_MAT;
            KIND_PRIME:                        state_nxt = ST_DIV;
            default:                           state_nxt = ST_SLOT;
          endcase
        end
      end
      ST_MAT:    if (status.row_last) state_nxt = ST_DRAIN;
      ST_DRAIN:  state_nxt = ST_INSERT;
      ST_DIV:    if (status.div_last) state_nxt = ST_INSERT;
      ST_INSERT: state_nxt = ST_SLOT;
      ST_EMIT:   if (status.emit_last) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        cmd.load   = start && !opcode;
        cmd.wr_row = start && opcode;
      end
      ST_SLOT: begin
        if (!status.slot_done) begin
          unique case (status.kind)
            KIND_SIMPLE, KIND_XOR, KIND_SHIFT: ;
            KIND_MATRIX:                       cmd.mat_start = 1'b1;
            KIND_PRIME:                        cmd.div_start = 1'b1;
            default:                           cmd.next_slot = 1'b1;
          endcase
        end
      end
      ST_MAT:    cmd.mat_step = 1'b1;
      ST_DRAIN:  ;
      ST_DIV:    cmd.div_step = 1'b1;
      ST_INSERT: begin
        cmd.insert    = 1'b1;
        cmd.next_slot = 1'b1;
      end
      ST_EMIT:   cmd.emit = 1'b1;
      default:   ;
    endcase
  end

endmodule

### sv/mhbi_dp.sv
// ----------------------------------------------------------------------------
// mhbi_dp
// Hash datapath: shifters, matrix row memory, serial remainder unit and the
// sorted, duplicate-free bucket list.
// ----------------------------------------------------------------------------
module mhbi_dp
  import mhbi_pkg::*;
#(
  parameter int NUM_SLOTS       = 4,
  parameter int MATRIX_ROWS     = 64,
  parameter int MAX_BUCKET_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  input  cfg_t                cfg,
  input  logic [ADDR_W-1:0]   in_address,
  input  logic [1:0]          in_slot_index,
  input  logic [5:0]          in_row_index,
  input  logic [15:0]         in_row_value,
  output status_t             status,
  output logic                out_valid,
  output logic [BUCKET_W-1:0] out_bucket,
  output logic                out_last
);

  localparam int DEPTH   = NUM_SLOTS * MATRIX_ROWS;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW      = (MATRIX_ROWS > 1) ? $clog2(MATRIX_ROWS) : 1;
  localparam int ACT_MAX = (NUM_SLOTS < KIND_FIELDS) ? NUM_SLOTS : KIND_FIELDS;

  logic [15:0]         mem [DEPTH];
  logic [DEPTH-1:0]    row_vld_r;
  logic [15:0]         rd_data_r;
  logic                rd_hit_r;
  logic                rd_pend_r;

  logic [ADDR_W-1:0]   addr_r;
  logic [2:0]          slot_r;
  logic [RW-1:0]       row_r;
  logic [15:0]         acc_r;
  logic [MOD_W-1:0]    rem_r;
  logic [5:0]          cnt_r;
  logic [BUCKET_W-1:0] vals_r [KIND_FIELDS];
  logic [2:0]          n_r;
  logic [1:0]          emit_r;
  logic                out_valid_r;
  logic [BUCKET_W-1:0] out_bucket_r;
  logic                out_last_r;

  logic [2:0]          active;
  logic [1:0]          sidx;
  logic [2:0]          kind;
  logic [5:0]          arg;
  logic [6:0]          shsum;
  logic [ADDR_W-1:0]   sa;
  logic [ADDR_W-1:0]   h;
  logic [4:0]          bb;
  logic [31:0]         mask;
  logic [31:0]         off;
  logic [31:0]         vsum;
  logic [BUCKET_W-1:0] v;
  logic                dup;
  logic [2:0]          pos;
  logic [AW-1:0]       wr_addr;
  logic                wr_ok;
  logic [AW-1:0]       rd_addr;
  logic [5:0]          bit_idx;
  logic [MOD_W:0]      div_t;

  always_comb begin
    active = cfg.slot_count;
    if (active > 3'(ACT_MAX)) active = 3'(ACT_MAX);
  end

  assign sidx  = slot_r[1:0];
  assign kind  = cfg.slot_kinds[3*sidx +: 3];
  assign arg   = cfg.slot_args[6*sidx +: 6];
  assign shsum = {1'b0, cfg.hash_shift} + {1'b0, arg};
  assign sa    = addr_r >> cfg.hash_shift;
  assign bb    = (cfg.bucket_bits > 5'(MAX_BUCKET_BITS)) ? 5'(MAX_BUCKET_BITS)
                                                        : cfg.bucket_bits;
  assign mask  = (32'd1 << bb) - 32'd1;

  always_comb begin
    unique case (kind)
      KIND_SIMPLE: h = sa;
      KIND_XOR:    h = sa ^ (addr_r >> arg);
      KIND_SHIFT:  h = shsum[6] ? '0 : (addr_r >> shsum[5:0]);
      KIND_MATRIX: h = {48'd0, acc_r};
      KIND_PRIME:  h = (cfg.prime_modulus == '0) ? addr_r : {47'd0, rem_r};
      default:     h = '0;
    endcase
  end

  assign off  = cfg.partitioned ? ({29'd0, slot_r} << bb) : 32'd0;
  assign vsum = (h[31:0] & mask) + off;
  assign v    = vsum[BUCKET_W-1:0];

  always_comb begin
    dup = 1'b0;
    pos = '0;
    for (int k = 0; k < KIND_FIELDS; k++) begin
      if (3'(k) < n_r) begin
        if (vals_r[k] == v) dup = 1'b1;
        if (vals_r[k] < v)  pos = pos + 3'd1;
      end
    end
  end

  assign wr_ok   = (int'(in_slot_index) < NUM_SLOTS) && (int'(in_row_index) < MATRIX_ROWS);
  assign wr_addr = AW'(int'(in_slot_index) * MATRIX_ROWS + int'(in_row_index));
  assign rd_addr = AW'(int'(sidx) * MATRIX_ROWS + int'(row_r));
  assign bit_idx = 6'(row_r);
  assign div_t   = {rem_r, addr_r[cnt_r]};

  always_ff @(posedge clk) begin
    if (cmd.wr_row && wr_ok) mem[wr_addr] <= in_row_value;
    rd_data_r <= mem[rd_addr];
    rd_hit_r  <= row_vld_r[rd_addr] && sa[bit_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r   <= '0;
      rd_pend_r   <= 1'b0;
      slot_r      <= '0;
      n_r         <= '0;
      emit_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.wr_row && wr_ok) row_vld_r[wr_addr] <= 1'b1;
      rd_pend_r   <= cmd.mat_step;
      out_valid_r <= cmd.emit;
      if (cmd.load) begin
        slot_r <= '0;
        n_r    <= '0;
        emit_r <= '0;
      end
      if (cmd.next_slot) slot_r <= slot_r + 3'd1;
      if (cmd.insert && !dup) n_r <= n_r + 3'd1;
      if (cmd.emit) emit_r <= emit_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) addr_r <= in_address;
    if (cmd.mat_start) begin
      row_r <= '0;
      acc_r <= '0;
    end else begin
      if (cmd.mat_step) row_r <= row_r + RW'(1);
      if (rd_pend_r && rd_hit_r) acc_r <= acc_r ^ rd_data_r;
    end
    if (cmd.div_start) begin
      rem_r <= '0;
      cnt_r <= 6'd63;
    end else if (cmd.div_step) begin
      rem_r <= (div_t >= {1'b0, cfg.prime_modulus})
               ? MOD_W'(div_t - {1'b0, cfg.prime_modulus}) : div_t[MOD_W-1:0];
      cnt_r <= cnt_r - 6'd1;
    end
    if (cmd.insert && !dup) begin
      if (pos == 3'd0) vals_r[0] <= v;
      for (int j = 1; j < KIND_FIELDS; j++) begin
        if (3'(j) == pos)     vals_r[j] <= v;
        else if (3'(j) > pos) vals_r[j] <= vals_r[j-1];
      end
    end
    if (cmd.emit) begin
      out_bucket_r <= vals_r[emit_r];
      out_last_r   <= status.emit_last;
    end
  end

  assign status.kind       = kind;
  assign status.slot_done  = (slot_r >= active);
  assign status.row_last   = (int'(row_r) == MATRIX_ROWS - 1);
  assign status.div_last   = (cnt_r == 6'd0);
  assign status.emit_last  = ({1'b0, emit_r} == n_r - 3'd1);
  assign status.list_empty = (n_r == '0);

  assign out_valid  = out_valid_r;
  assign out_bucket = out_bucket_r;
  assign out_last   = out_last_r;

endmodule

### sv/multi_hash_bucket_index.sv
// ----------------------------------------------------------------------------
// multi_hash_bucket_index
// Hashes a 64-bit address through up to four configured slots and returns
// the distinct bucket indices in ascending order.
//
// A command is taken when start is high and busy is low. Opcode 1 writes one
// matrix row in that cycle and produces no beat. Opcode 0 hashes the address;
// the block then walks the active slots in turn, each from the slot state: a
// select, XOR or shift slot then visits the insert state, a skipped slot no
// other, a matrix slot a row step per row (one row read per cycle from the
// row memory), a drain and the insert state, a prime slot a step per address
// bit (the remainder unit retires one address bit per cycle) and the insert
// state. A last slot visit closes the walk; the buckets then leave as
// consecutive beats on out_valid, one per cycle, the last marked by out_last.
// Each beat is shown for exactly one cycle and the receiver cannot stall it;
// busy falls as the final beat appears, so the next command may be taken
// then. The config port is always ready and writes take effect at once; the
// user must write it only while the block is idle; this is not enforced.
// Reset is synchronous: sequencer idle, registers reset, matrix rows zero.
// ----------------------------------------------------------------------------
module multi_hash_bucket_index
  import mhbi_pkg::*;
#(
  parameter int NUM_SLOTS       = 4,
  parameter int MATRIX_ROWS     = 64,
  parameter int MAX_BUCKET_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_opcode,
  input  logic [ADDR_W-1:0]   in_address,
  input  logic [1:0]          in_slot_index,
  input  logic [5:0]          in_row_index,
  input  logic [15:0]         in_row_value,
  output logic                out_valid,
  output logic [BUCKET_W-1:0] out_bucket,
  output logic                out_last,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  mhbi_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mhbi_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .opcode (in_opcode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  mhbi_dp #(
    .NUM_SLOTS       (NUM_SLOTS),
    .MATRIX_ROWS     (MATRIX_ROWS),
    .MAX_BUCKET_BITS (MAX_BUCKET_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .cfg           (cfg),
    .in_address    (in_address),
    .in_slot_index (in_slot_index),
    .in_row_index  (in_row_index),
    .in_row_value  (in_row_value),
    .status        (status),
    .out_valid     (out_valid),
    .out_bucket    (out_bucket),
    .out_last      (out_last)
  );

endmodule

### sv/mhbi_checker.sv
// ----------------------------------------------------------------------------
// mhbi_checker
// Port-level checks on the command and result channels, bound to the top.
// ----------------------------------------------------------------------------
module mhbi_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_opcode,
  input logic out_valid,
  input logic out_last
);

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("Block not idle after reset.");

  a_burst_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("Gap inside a result burst.");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("Beat directly after the final beat.");

  a_busy_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("Idle while a burst is still running.");

  a_row_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_opcode |=> !out_valid && !busy)
    else $error("Row write produced activity.");

endmodule

bind multi_hash_bucket_index mhbi_checker u_mhbi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_opcode (in_opcode),
  .out_valid (out_valid),
  .out_last  (out_last)
);
